// ----- design/pngts_pkg.sv -----
// Package for the PNG/JPEG transparency scanner.
// Holds parse phase codes, verdict codes, register indexes and chunk type words.
// No dependencies.
package pngts_pkg;

    localparam int LENGTH_BITS_DEFAULT = 32;

    localparam int FIELD_W = 32;   // chunk length, type word, field counter
    localparam int FLEN_W  = 32;   // file_length register

    // parse phases
    localparam logic [2:0] PH_SIG  = 3'd0;
    localparam logic [2:0] PH_LEN  = 3'd1;
    localparam logic [2:0] PH_TYPE = 3'd2;
    localparam logic [2:0] PH_DATA = 3'd3;
    localparam logic [2:0] PH_CRC  = 3'd4;
    localparam logic [2:0] PH_DONE = 3'd5;

    // verdicts
    localparam logic [1:0] VERDICT_MISMATCH    = 2'd0;
    localparam logic [1:0] VERDICT_OPAQUE      = 2'd1;
    localparam logic [1:0] VERDICT_TRANSPARENT = 2'd2;

    // configuration register indexes
    localparam logic REG_IMAGE_FORMAT = 1'b0;
    localparam logic REG_FILE_LENGTH  = 1'b1;

    localparam logic FMT_PNG  = 1'b0;
    localparam logic FMT_JPEG = 1'b1;

    localparam logic [31:0] TYPE_IHDR = 32'h4948_4452;
    localparam logic [31:0] TYPE_TRNS = 32'h7452_4E53;
    localparam logic [31:0] TYPE_IEND = 32'h4945_4E44;

    localparam logic [7:0] JPEG_MARK  = 8'hFF;
    localparam logic [7:0] JPEG_SOI   = 8'hD8;
    localparam logic [7:0] JPEG_EOI   = 8'hD9;

    localparam logic [7:0] COLOR_GRAY_ALPHA = 8'd4;
    localparam logic [7:0] COLOR_RGB_ALPHA  = 8'd6;

    localparam int CHUNK_OVERHEAD = 12;  // length + type + CRC
    localparam int IHDR_MIN_LEN   = 13;
    localparam int COLOR_TYPE_OFS = 9;
    localparam int SIG_LEN        = 8;

    function automatic logic [7:0] png_magic(input logic [2:0] idx);
        logic [7:0] m;
        case (idx)
            3'd0:    m = 8'h89;
            3'd1:    m = 8'h50;
            3'd2:    m = 8'h4E;
            3'd3:    m = 8'h47;
            3'd4:    m = 8'h0D;
            3'd5:    m = 8'h0A;
            3'd6:    m = 8'h1A;
            3'd7:    m = 8'h0A;
            default: m = 8'h00;
        endcase
        return m;
    endfunction

endpackage

// ----- design/png_chunk_transparency_scanner_unit.sv -----
// Top level of the PNG/JPEG transparency scanner: byte-wide chunk walker.
// Output: the verdict word is registered when the last byte is accepted.
// Throughput: one byte per cycle when in_ready is high; every state update is counter and
// compare logic between the input handshake and the state/result registers.
// Reset: asynchronous, active low; clears parse state, config and output valid.
// Parse state also returns to reset after every verdict.
module png_chunk_transparency_scanner_unit
    import pngts_pkg::*;
#(
    parameter int LENGTH_BITS = LENGTH_BITS_DEFAULT
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [FLEN_W-1:0]   cfg_data,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [7:0]          byte_value,
    input  logic                last_byte,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [1:0]          verdict
);

    localparam int WIDE_W = ((LENGTH_BITS > FLEN_W) ? LENGTH_BITS : FLEN_W) + 2;
    localparam logic [LENGTH_BITS-1:0] POS_MAX = {LENGTH_BITS{1'b1}};

    logic                   fmt_reg;
    logic [FLEN_W-1:0]      flen_reg;

    logic [LENGTH_BITS-1:0] pos_reg, pos_next;
    logic [2:0]             phase_reg, phase_next;
    logic [FIELD_W-1:0]     left_reg, left_next;
    logic [FIELD_W-1:0]     clen_reg, clen_next;
    logic [FIELD_W-1:0]     ctype_reg, ctype_next;
    logic                   sig_good_reg, sig_good_next;
    logic                   decided_reg, decided_next;
    logic [1:0]             held_reg, held_next;
    logic [7:0]             prev_reg, prev_next;
    logic                   watch_reg, watch_next;

    logic                   out_valid_reg;
    logic [1:0]             verdict_reg;
    logic [1:0]             result;

    logic                   accept;
    logic                   field_done;
    logic [FIELD_W-1:0]     left_dec;
    logic [FIELD_W-1:0]     clen_shift;
    logic [FIELD_W-1:0]     ctype_shift;
    logic [LENGTH_BITS-1:0] chk_off;
    logic [FIELD_W-1:0]     chk_len;
    logic [WIDE_W-1:0]      chk_sum;
    logic                   chunk_fits;
    logic [LENGTH_BITS-1:0] pos_inc;

    assign accept   = in_valid && in_ready;
    assign in_ready = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign verdict   = verdict_reg;

    assign left_dec    = left_reg - FIELD_W'(1);
    assign field_done  = (left_reg == FIELD_W'(1));
    assign clen_shift  = {clen_reg[FIELD_W-9:0], byte_value};
    assign ctype_shift = {ctype_reg[FIELD_W-9:0], byte_value};
    assign pos_inc     = (pos_reg != POS_MAX) ? pos_reg + LENGTH_BITS'(1) : pos_reg;

    // chunk bound check: offset + length + 12 must not pass file_length
    always_comb
    begin
        case (phase_reg)
            PH_LEN:
            begin
                chk_off = (pos_reg >= LENGTH_BITS'(3)) ? pos_reg - LENGTH_BITS'(3) : '0;
                chk_len = clen_shift;
            end
            PH_CRC:
            begin
                chk_off = pos_inc;
                chk_len = '0;
            end
            default:
            begin
                chk_off = LENGTH_BITS'(SIG_LEN);
                chk_len = '0;
            end
        endcase
    end

    assign chk_sum    = WIDE_W'(chk_off) + WIDE_W'(chk_len) + WIDE_W'(CHUNK_OVERHEAD);
    assign chunk_fits = (chk_sum <= WIDE_W'(flen_reg));

    always_comb
    begin
        pos_next      = pos_reg;
        phase_next    = phase_reg;
        left_next     = left_reg;
        clen_next     = clen_reg;
        ctype_next    = ctype_reg;
        sig_good_next = sig_good_reg;
        decided_next  = decided_reg;
        held_next     = held_reg;
        prev_next     = prev_reg;
        watch_next    = watch_reg;
        result        = VERDICT_MISMATCH;

        if (fmt_reg == FMT_PNG)
        begin
            if (!decided_reg)
            begin
                case (phase_reg)
                    PH_SIG:
                    begin
                        if (byte_value != png_magic(pos_reg[2:0]))
                            sig_good_next = 1'b0;
                        if (pos_reg >= LENGTH_BITS'(SIG_LEN - 1))
                        begin
                            if (chunk_fits)
                            begin
                                phase_next = PH_LEN;
                                left_next  = FIELD_W'(4);
                                clen_next  = '0;
                            end
                            else
                            begin
                                decided_next = 1'b1;
                                held_next    = VERDICT_OPAQUE;
                                phase_next   = PH_DONE;
                            end
                        end
                    end
                    PH_LEN:
                    begin
                        clen_next = clen_shift;
                        left_next = left_dec;
                        if (field_done)
                        begin
                            if (chunk_fits)
                            begin
                                phase_next = PH_TYPE;
                                left_next  = FIELD_W'(4);
                                ctype_next = '0;
                            end
                            else
                            begin
                                decided_next = 1'b1;
                                held_next    = VERDICT_OPAQUE;
                                phase_next   = PH_DONE;
                            end
                        end
                    end
                    PH_TYPE:
                    begin
                        ctype_next = ctype_shift;
                        left_next  = left_dec;
                        if (field_done)
                        begin
                            if (ctype_shift == TYPE_TRNS)
                            begin
                                decided_next = 1'b1;
                                held_next    = VERDICT_TRANSPARENT;
                                phase_next   = PH_DONE;
                            end
                            else if (ctype_shift == TYPE_IEND)
                            begin
                                decided_next = 1'b1;
                                held_next    = VERDICT_OPAQUE;
                                phase_next   = PH_DONE;
                            end
                            else
                            begin
                                watch_next = (ctype_shift == TYPE_IHDR)
                                          && (clen_reg >= FIELD_W'(IHDR_MIN_LEN));
                                if (clen_reg == '0)
                                begin
                                    phase_next = PH_CRC;
                                    left_next  = FIELD_W'(4);
                                end
                                else
                                begin
                                    phase_next = PH_DATA;
                                    left_next  = clen_reg;
                                end
                            end
                        end
                    end
                    PH_DATA:
                    begin
                        // offset within the data is length minus bytes left
                        if (watch_reg && (clen_reg - left_reg == FIELD_W'(COLOR_TYPE_OFS))
                            && (byte_value == COLOR_GRAY_ALPHA
                                || byte_value == COLOR_RGB_ALPHA))
                        begin
                            decided_next = 1'b1;
                            held_next    = VERDICT_TRANSPARENT;
                            phase_next   = PH_DONE;
                        end
                        else
                        begin
                            left_next = left_dec;
                            if (field_done)
                            begin
                                phase_next = PH_CRC;
                                left_next  = FIELD_W'(4);
                            end
                        end
                    end
                    PH_CRC:
                    begin
                        left_next = left_dec;
                        if (field_done)
                        begin
                            if (chunk_fits)
                            begin
                                phase_next = PH_LEN;
                                left_next  = FIELD_W'(4);
                                clen_next  = '0;
                            end
                            else
                            begin
                                decided_next = 1'b1;
                                held_next    = VERDICT_OPAQUE;
                                phase_next   = PH_DONE;
                            end
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end

            if (!sig_good_next || phase_next == PH_SIG)
                result = VERDICT_MISMATCH;
            else if (decided_next)
                result = held_next;
            else
                result = VERDICT_OPAQUE;
        end
        else
        begin
            if (pos_reg == '0 && byte_value != JPEG_MARK)
                sig_good_next = 1'b0;
            if (pos_reg == LENGTH_BITS'(1) && byte_value != JPEG_SOI)
                sig_good_next = 1'b0;
            result = (sig_good_next && pos_reg >= LENGTH_BITS'(3)
                      && prev_reg == JPEG_MARK && byte_value == JPEG_EOI)
                     ? VERDICT_OPAQUE : VERDICT_MISMATCH;
        end

        if (last_byte)
        begin
            pos_next      = '0;
            phase_next    = PH_SIG;
            left_next     = '0;
            clen_next     = '0;
            ctype_next    = '0;
            sig_good_next = 1'b1;
            decided_next  = 1'b0;
            held_next     = VERDICT_MISMATCH;
            prev_next     = '0;
            watch_next    = 1'b0;
        end
        else
        begin
            pos_next  = pos_inc;
            prev_next = byte_value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fmt_reg  <= FMT_PNG;
            flen_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_IMAGE_FORMAT: fmt_reg  <= cfg_data[0];
                REG_FILE_LENGTH:  flen_reg <= cfg_data;
                default:          fmt_reg  <= fmt_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= '0;
            phase_reg    <= PH_SIG;
            left_reg     <= '0;
            clen_reg     <= '0;
            ctype_reg    <= '0;
            sig_good_reg <= 1'b1;
            decided_reg  <= 1'b0;
            held_reg     <= VERDICT_MISMATCH;
            prev_reg     <= '0;
            watch_reg    <= 1'b0;
        end
        else if (accept)
        begin
            pos_reg      <= pos_next;
            phase_reg    <= phase_next;
            left_reg     <= left_next;
            clen_reg     <= clen_next;
            ctype_reg    <= ctype_next;
            sig_good_reg <= sig_good_next;
            decided_reg  <= decided_next;
            held_reg     <= held_next;
            prev_reg     <= prev_next;
            watch_reg    <= watch_next;
        end
    end

    // result word register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (accept && last_byte)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept && last_byte)
            verdict_reg <= result;
    end

endmodule

// ----- sim/tb_png_chunk_transparency_scanner_unit.sv -----
// Self-checking testbench for png_chunk_transparency_scanner_unit: directed byte table,
// then random PNG/JPEG/noise files checked against an in-bench verdict predictor.
// Depends on pngts_pkg and the scanner RTL only.
module tb_png_chunk_transparency_scanner_unit;
    import pngts_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          CLK_PERIOD     = 10;
    localparam int          RANDOM_BYTES   = 1100;
    localparam int          MIN_FILES      = 48;
    localparam int          CHOKE_CYCLES   = 250;
    localparam int          MAX_SHOWN      = 10;
    localparam logic [63:0] PNG_SIG        = 64'h8950_4E47_0D0A_1A0A;
    localparam logic [63:0] POS_LIMIT      = 64'h0000_0000_FFFF_FFFF;
    localparam logic [31:0] TYPE_IDAT      = 32'h4944_4154;
    localparam logic [1:0]  WANT_PREDICTED = 2'd3;   // row has no typed verdict

    typedef struct packed {
        logic        setup;
        logic        fmt;
        logic [31:0] flen;
        logic [7:0]  data;
        logic        lst;
        logic [1:0]  want;
    } dir_row_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic        cfg_index;
    logic [31:0] cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  byte_value;
    logic        last_byte;
    logic        out_valid;
    logic        out_ready;
    logic [1:0]  verdict;

    // predictor copy of registers and walk state
    logic        fmt_q;
    logic [63:0] flen_q;
    logic [63:0] pos_q;
    logic [2:0]  phase_q;
    logic [63:0] left_q;
    logic [31:0] clen_q;
    logic [31:0] ctype_q;
    logic        sig_ok_q;
    logic        decided_q;
    logic [1:0]  held_q;
    logic [7:0]  prev_q;
    logic        watch_q;

    logic [1:0]  due_verdicts[$];
    logic [1:0]  due;
    logic [7:0]  file_q[$];
    dir_row_t    dir_rows[$];

    int          mismatches = 0;
    int          bytes_sent = 0;
    int          files_done = 0;
    bit          calm = 0;
    bit          choke_req = 0;
    bit          choke_done = 0;
    int          choke_left = 0;

    png_chunk_transparency_scanner_unit i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .byte_value (byte_value),
        .last_byte  (last_byte),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .verdict    (verdict)
    );

    initial clk = 1'b0;
    always #(CLK_PERIOD / 2) clk = ~clk;

    // ---------------- predictor ----------------

    function automatic void walk_restart();
        pos_q     = '0;
        phase_q   = PH_SIG;
        left_q    = '0;
        clen_q    = '0;
        ctype_q   = '0;
        sig_ok_q  = 1'b1;
        decided_q = 1'b0;
        held_q    = VERDICT_MISMATCH;
        prev_q    = '0;
        watch_q   = 1'b0;
    endfunction

    function automatic void settle(input logic [1:0] v);
        decided_q = 1'b1;
        held_q    = v;
        phase_q   = PH_DONE;
    endfunction

    function automatic bit overruns(input logic [63:0] ofs);
        return ofs > flen_q || flen_q - ofs < CHUNK_OVERHEAD;
    endfunction

    function automatic void open_chunk(input logic [63:0] ofs);
        if (overruns(ofs))
        begin
            settle(VERDICT_OPAQUE);
        end
        else
        begin
            phase_q = PH_LEN;
            left_q  = 4;
            clen_q  = '0;
        end
    endfunction

    function automatic void png_walk(input logic [7:0] b);
        logic [63:0] ofs;
        case (phase_q)
            PH_SIG:
            begin
                if (b != PNG_SIG[63 - 8 * pos_q[2:0] -: 8])
                    sig_ok_q = 1'b0;
                if (pos_q >= SIG_LEN - 1)
                    open_chunk(SIG_LEN);
            end
            PH_LEN:
            begin
                clen_q = {clen_q[23:0], b};
                left_q--;
                if (left_q == 0)
                begin
                    ofs = (pos_q >= 3) ? pos_q - 3 : 64'd0;
                    if (overruns(ofs))
                        settle(VERDICT_OPAQUE);
                    else if ({32'd0, clen_q} > flen_q - ofs - CHUNK_OVERHEAD)
                        settle(VERDICT_OPAQUE);
                    else
                    begin
                        phase_q = PH_TYPE;
                        left_q  = 4;
                        ctype_q = '0;
                    end
                end
            end
            PH_TYPE:
            begin
                ctype_q = {ctype_q[23:0], b};
                left_q--;
                if (left_q == 0)
                begin
                    if (ctype_q == TYPE_TRNS)
                        settle(VERDICT_TRANSPARENT);
                    else if (ctype_q == TYPE_IEND)
                        settle(VERDICT_OPAQUE);
                    else
                    begin
                        watch_q = (ctype_q == TYPE_IHDR) && (clen_q >= IHDR_MIN_LEN);
                        phase_q = (clen_q == 0) ? PH_CRC : PH_DATA;
                        left_q  = (clen_q == 0) ? 64'd4 : {32'd0, clen_q};
                    end
                end
            end
            PH_DATA:
            begin
                // color type sits at data offset 9 of a full-size IHDR
                if (watch_q && {32'd0, clen_q} - left_q == COLOR_TYPE_OFS
                    && (b == COLOR_GRAY_ALPHA || b == COLOR_RGB_ALPHA))
                    settle(VERDICT_TRANSPARENT);
                else
                begin
                    left_q--;
                    if (left_q == 0)
                    begin
                        phase_q = PH_CRC;
                        left_q  = 4;
                    end
                end
            end
            PH_CRC:
            begin
                left_q--;
                if (left_q == 0)
                    open_chunk((pos_q < POS_LIMIT) ? pos_q + 1 : pos_q);
            end
            default: ;
        endcase
    endfunction

    // Returns 1 when the byte ends a file, with the verdict in v.
    function automatic bit predict_verdict(input logic [7:0] b, input logic lst,
                                           output logic [1:0] v);
        v = VERDICT_MISMATCH;
        if (fmt_q == FMT_PNG)
        begin
            if (!decided_q)
                png_walk(b);
            if (lst)
            begin
                if (!sig_ok_q || phase_q == PH_SIG)
                    v = VERDICT_MISMATCH;
                else if (decided_q)
                    v = held_q;
                else
                    v = VERDICT_OPAQUE;
            end
        end
        else
        begin
            if (pos_q == 0 && b != JPEG_MARK)
                sig_ok_q = 1'b0;
            if (pos_q == 1 && b != JPEG_SOI)
                sig_ok_q = 1'b0;
            if (lst)
                v = (sig_ok_q && pos_q >= 3 && prev_q == JPEG_MARK && b == JPEG_EOI)
                    ? VERDICT_OPAQUE : VERDICT_MISMATCH;
        end
        if (lst)
        begin
            walk_restart();
            return 1'b1;
        end
        if (pos_q < POS_LIMIT)
            pos_q++;
        prev_q = b;
        return 1'b0;
    endfunction

    // ---------------- drivers ----------------

    task automatic push_byte(input logic [7:0] data, input logic lst, input logic [1:0] want);
        logic [1:0] got;
        @(negedge clk);
        while (!calm && $urandom_range(99) < 27)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid   <= 1'b1;
        byte_value <= data;
        last_byte  <= lst;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        bytes_sent++;
        calm = bytes_sent >= 500 && bytes_sent < 700;
        if (bytes_sent >= 300)
            choke_req = 1'b1;
        if (predict_verdict(data, lst, got))
            due_verdicts = {due_verdicts, (want == WANT_PREDICTED) ? got : want};
    endtask

    // Stop sending and let every pending verdict drain.
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (due_verdicts.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [31:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_IMAGE_FORMAT)
            fmt_q = value[0];
        else
            flen_q = {32'd0, value};
    endtask

    function automatic void add_row(input logic setup, input logic fmt,
                                    input logic [31:0] flen, input logic [7:0] data,
                                    input logic lst, input logic [1:0] want);
        dir_row_t r;
        r.setup = setup;
        r.fmt   = fmt;
        r.flen  = flen;
        r.data  = data;
        r.lst   = lst;
        r.want  = want;
        dir_rows = {dir_rows, r};
    endfunction

    // ---------------- random file builders ----------------

    task automatic add_word(input logic [31:0] w);
        for (int k = 3; k >= 0; k--)
            file_q = {file_q, w[8 * k +: 8]};
    endtask

    task automatic add_chunk(input logic [31:0] len_field, input logic [31:0] kind,
                             input int body, input logic [7:0] color);
        add_word(len_field);
        add_word(kind);
        for (int k = 0; k < body; k++)
            file_q = {file_q, (kind == TYPE_IHDR && k == COLOR_TYPE_OFS) ? color
                                                                         : 8'($urandom)};
        add_word($urandom);
    endtask

    task automatic make_file(output logic fmt, output logic [31:0] flen);
        int          pick;
        int          len;
        int          n;
        int          idx;
        logic [31:0] kind;
        logic [7:0]  color;
        file_q.delete();
        pick = $urandom_range(99);
        if (pick < 55)
        begin
            fmt = FMT_PNG;
            add_word(PNG_SIG[63:32]);
            add_word(PNG_SIG[31:0]);
            if ($urandom_range(9) == 0)
            begin
                idx = $urandom_range(7);
                file_q[idx] = file_q[idx] ^ 8'($urandom_range(1, 255));
            end
            if ($urandom_range(4) != 0)
            begin
                case ($urandom_range(4))
                    0:       color = 8'd0;
                    1:       color = 8'd2;
                    2:       color = 8'd3;
                    3:       color = COLOR_GRAY_ALPHA;
                    default: color = COLOR_RGB_ALPHA;
                endcase
                len = ($urandom_range(3) == 0) ? $urandom_range(9, 16) : IHDR_MIN_LEN;
                add_chunk(len, TYPE_IHDR, len, color);
            end
            n = $urandom_range(3);
            for (int c = 0; c < n; c++)
            begin
                len  = $urandom_range(8);
                kind = $urandom_range(1) ? TYPE_IDAT : $urandom;
                // now and then a length field that runs past the end of the file
                add_chunk(($urandom_range(9) == 0) ? $urandom : len, kind, len, 8'h00);
            end
            case ($urandom_range(2))
                0:       add_chunk($urandom_range(6), TYPE_TRNS, 0, 8'h00);
                1:       add_chunk(0, TYPE_IEND, 0, 8'h00);
                default: ;
            endcase
            if ($urandom_range(99) < 15)
            begin
                idx = $urandom_range(1, file_q.size() - 1);
                file_q = file_q[0:idx-1];
            end
            n = $urandom_range(9);
            if (n < 7)
                flen = file_q.size();
            else if (n == 7)
                flen = file_q.size() + $urandom_range(20) - 10;
            else if (n == 8)
                flen = $urandom_range(1) ? 32'hFFFF_FFFF : 32'd0;
            else
                flen = $urandom;
        end
        else if (pick < 80)
        begin
            fmt = FMT_JPEG;
            file_q = {file_q, JPEG_MARK};
            file_q = {file_q, JPEG_SOI};
            n = $urandom_range(16);
            for (int k = 0; k < n; k++)
                file_q = {file_q, 8'($urandom)};
            file_q = {file_q, JPEG_MARK};
            file_q = {file_q, JPEG_EOI};
            case ($urandom_range(9))
                0, 1:
                begin
                    n = $urandom_range(3);
                    idx = (n < 2) ? n : file_q.size() - 4 + n;
                    file_q[idx] = file_q[idx] ^ 8'($urandom_range(1, 255));
                end
                2:
                begin
                    idx = $urandom_range(1, 3);
                    file_q = file_q[0:idx-1];
                end
                default: ;
            endcase
            flen = $urandom;
        end
        else
        begin
            fmt = 1'($urandom_range(1));
            n = $urandom_range(1, 12);
            for (int k = 0; k < n; k++)
                file_q = {file_q, 8'($urandom)};
            flen = $urandom_range(1) ? 32'(n) : $urandom;
        end
    endtask

    // ---------------- receiver ----------------

    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (choke_left > 0)
            begin
                choke_left--;
                out_ready <= 1'b0;
            end
            else if (choke_req && !choke_done)
            begin
                // one long hold-off so the block backs up into its input
                choke_done = 1'b1;
                choke_left = CHOKE_CYCLES;
                out_ready <= 1'b0;
            end
            else
                out_ready <= calm || ($urandom_range(99) >= 27);
        end
    end

    // ---------------- result checker ----------------

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (due_verdicts.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_SHOWN)
                    $display("%0t: verdict word %0d with nothing pending", $time, verdict);
            end
            else
            begin
                due = due_verdicts.pop_front();
                if (verdict !== due)
                begin
                    mismatches++;
                    if (mismatches <= MAX_SHOWN)
                        $display("%0t: verdict expected %0d, got %0d", $time, due, verdict);
                end
            end
        end
    end

    // ---------------- stimulus ----------------

    initial
    begin
        logic        fmt;
        logic [31:0] flen;
        int          split;
        rst_n      = 1'b0;
        cfg_we     = 1'b0;
        cfg_index  = REG_IMAGE_FORMAT;
        cfg_data   = '0;
        in_valid   = 1'b0;
        byte_value = '0;
        last_byte  = 1'b0;
        fmt_q      = FMT_PNG;
        flen_q     = '0;
        walk_restart();

        // well-formed JPEG, then one a byte too short
        add_row(1, FMT_JPEG, 32'd0, JPEG_MARK, 0, WANT_PREDICTED);
        add_row(0, FMT_JPEG, 32'd0, JPEG_SOI,  0, WANT_PREDICTED);
        add_row(0, FMT_JPEG, 32'd0, JPEG_MARK, 0, WANT_PREDICTED);
        add_row(0, FMT_JPEG, 32'd0, JPEG_EOI,  1, VERDICT_OPAQUE);
        add_row(0, FMT_JPEG, 32'd0, JPEG_MARK, 0, WANT_PREDICTED);
        add_row(0, FMT_JPEG, 32'd0, JPEG_SOI,  0, WANT_PREDICTED);
        add_row(0, FMT_JPEG, 32'd0, JPEG_EOI,  1, VERDICT_MISMATCH);
        // PNG cut short inside the signature
        add_row(1, FMT_PNG, 32'd8, 8'h89, 1, VERDICT_MISMATCH);
        // signature only: no room for a chunk, trailing bytes ignored
        for (int k = 0; k < SIG_LEN; k++)
            add_row(0, FMT_PNG, 32'd8, PNG_SIG[63 - 8 * k -: 8], 0, WANT_PREDICTED);
        add_row(0, FMT_PNG, 32'd8, 8'hFF, 0, WANT_PREDICTED);
        add_row(0, FMT_PNG, 32'd8, 8'h00, 1, VERDICT_OPAQUE);
        // largest file length: walk still open at the last byte
        for (int k = 0; k < SIG_LEN; k++)
            add_row(k == 0, FMT_PNG, 32'hFFFF_FFFF, PNG_SIG[63 - 8 * k -: 8],
                    0, WANT_PREDICTED);
        add_row(0, FMT_PNG, 32'hFFFF_FFFF, 8'h00, 1, WANT_PREDICTED);

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].setup)
            begin
                drain();
                write_reg(REG_IMAGE_FORMAT, {31'd0, dir_rows[i].fmt});
                write_reg(REG_FILE_LENGTH, dir_rows[i].flen);
            end
            push_byte(dir_rows[i].data, dir_rows[i].lst, dir_rows[i].want);
        end

        while (bytes_sent < RANDOM_BYTES || files_done < MIN_FILES)
        begin
            make_file(fmt, flen);
            if ($urandom_range(99) < 65 && choke_left == 0)
            begin
                drain();
                write_reg(REG_IMAGE_FORMAT, {31'd0, fmt});
                write_reg(REG_FILE_LENGTH, flen);
            end
            // occasionally rewrite a register in the middle of a file
            split = ($urandom_range(99) < 8 && file_q.size() > 1)
                    ? $urandom_range(1, file_q.size() - 1) : -1;
            foreach (file_q[i])
            begin
                if (i == split)
                begin
                    drain();
                    if ($urandom_range(1))
                        write_reg(REG_IMAGE_FORMAT, {31'd0, ~fmt_q});
                    else
                        write_reg(REG_FILE_LENGTH, $urandom_range(1) ? $urandom_range(64)
                                                                     : $urandom);
                end
                push_byte(file_q[i], i == file_q.size() - 1, WANT_PREDICTED);
            end
            files_done++;
        end

        @(negedge clk);
        in_valid <= 1'b0;
        while (due_verdicts.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (mismatches == 0 && due_verdicts.size() == 0)
            $display("** png_chunk_transparency_scanner_unit: PASSED **");
        else
            $display("** png_chunk_transparency_scanner_unit: FAILED **");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("** png_chunk_transparency_scanner_unit: FAILED **");
        $finish;
    end

endmodule
